// File: hdl/sba_pkg.sv
package sba_pkg;

  // Field widths of the request and response transactions.
  localparam int CMD_W    = 1;
  localparam int VSIZE_W  = 11;
  localparam int OFF_W    = 32;
  localparam int FCLS_W   = 6;
  localparam int STATUS_W = 3;
  localparam int BLK_W    = 6;
  localparam int PIDX_W   = 4;

  // Configuration port geometry.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Largest value length accepted and largest block count granted.
  localparam int MAX_VALUE  = 1024;
  localparam int MAX_BLOCKS = 63;

  // Classes examined per cycle by the free-list search.
  localparam int SCAN_LANES = 8;
  localparam int LANE_W     = 3;

  // Default configuration of the allocator.
  localparam int DEF_BLOCK_BYTES   = 32;
  localparam int DEF_HEADER_BYTES  = 22;
  localparam int DEF_SIZE_CLASSES  = 64;
  localparam int DEF_LIST_DEPTH    = 1024;
  localparam int DEF_REGION_BLOCKS = 1048576;

  // Request codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_LOG     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LIST    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic free_commit;
    logic nospace;
    logic log_grant;
    logic scan_start;
    logic scan_step;
    logic pop_count;
    logic list_result;
    logic out_load;
  } sba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_free;
    logic oversize;
    logic log_fits;
    logic scan_hit;
    logic scan_done;
    logic out_free;
  } sba_stat_t;

endpackage

// File: hdl/sba_if.sv
// Request channel: one allocate or free transaction.
interface sba_in_if;
  logic                          valid;
  logic                          ready;
  logic [sba_pkg::CMD_W-1:0]     cmd;
  logic [sba_pkg::VSIZE_W-1:0]   value_size;
  logic [sba_pkg::OFF_W-1:0]     free_offset;
  logic [sba_pkg::FCLS_W-1:0]    free_class;

  modport source (output valid, cmd, value_size, free_offset, free_class, input ready);
  modport sink (input valid, cmd, value_size, free_offset, free_class, output ready);
endinterface

// Response channel: one result transaction per request.
interface sba_out_if;
  logic                          valid;
  logic                          ready;
  logic [sba_pkg::STATUS_W-1:0]  status;
  logic [sba_pkg::OFF_W-1:0]     offset;
  logic [sba_pkg::BLK_W-1:0]     blocks_granted;

  modport source (output valid, status, offset, blocks_granted, input ready);
  modport sink (input valid, status, offset, blocks_granted, output ready);
endinterface

// File: hdl/sba_ram.sv
module sba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: hdl/sba_ctrl.sv
module sba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sba_pkg::sba_stat_t stat_i,
  output sba_pkg::sba_cmd_t  cmd_o
);
  import sba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FREE_WR,
    S_ALLOC_CHK,
    S_SCAN,
    S_POP_CNT,
    S_POP_RD,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready_o = (state_r == S_IDLE);

  // Command decode and next state.
  always_comb begin
    cmd_o     = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      // Block count is computed and the class count is read here.
      S_DECODE: begin
        state_nxt = stat_i.is_free ? S_FREE_WR : S_ALLOC_CHK;
      end
      S_FREE_WR: begin
        cmd_o.free_commit = 1'b1;
        state_nxt         = S_OUT;
      end
      S_ALLOC_CHK: begin
        priority if (stat_i.oversize) begin
          cmd_o.nospace = 1'b1;
          state_nxt     = S_OUT;
        end else if (stat_i.log_fits) begin
          cmd_o.log_grant = 1'b1;
          state_nxt       = S_OUT;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_nxt        = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        priority if (stat_i.scan_hit) begin
          state_nxt = S_POP_CNT;
        end else if (stat_i.scan_done) begin
          cmd_o.nospace = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_POP_CNT: begin
        cmd_o.pop_count = 1'b1;
        state_nxt       = S_POP_RD;
      end
      S_POP_RD: begin
        cmd_o.list_result = 1'b1;
        state_nxt         = S_OUT;
      end
      // Wait for the response register to drain.
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/sba_datapath.sv
module sba_datapath #(
  parameter int BLOCK_BYTES   = sba_pkg::DEF_BLOCK_BYTES,
  parameter int HEADER_BYTES  = sba_pkg::DEF_HEADER_BYTES,
  parameter int SIZE_CLASSES  = sba_pkg::DEF_SIZE_CLASSES,
  parameter int LIST_DEPTH    = sba_pkg::DEF_LIST_DEPTH,
  parameter int REGION_BLOCKS = sba_pkg::DEF_REGION_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sba_pkg::sba_cmd_t             cmd_i,
  output sba_pkg::sba_stat_t            stat_o,
  input  logic [sba_pkg::CMD_W-1:0]     in_cmd_i,
  input  logic [sba_pkg::VSIZE_W-1:0]   in_value_size_i,
  input  logic [sba_pkg::OFF_W-1:0]     in_free_offset_i,
  input  logic [sba_pkg::FCLS_W-1:0]    in_free_class_i,
  input  logic                          cfg_we_i,
  input  logic [sba_pkg::PIDX_W-1:0]    cfg_wdata_i,
  output logic [sba_pkg::PIDX_W-1:0]    pidx_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sba_pkg::STATUS_W-1:0]  out_status_o,
  output logic [sba_pkg::OFF_W-1:0]     out_offset_o,
  output logic [sba_pkg::BLK_W-1:0]     out_blocks_o
);
  import sba_pkg::*;

  localparam int CLS_W   = $clog2(SIZE_CLASSES);
  localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int ST_AW   = $clog2(SIZE_CLASSES * LIST_DEPTH);
  localparam int HEAD_W  = $clog2(REGION_BLOCKS);
  localparam int SCAN_W  = $clog2(SIZE_CLASSES + SCAN_LANES + 64);
  localparam int OVER_LIM = (MAX_BLOCKS + 1) * BLOCK_BYTES;
  localparam int DIV_TOP  = (2 ** VSIZE_W) - 1 + HEADER_BYTES + BLOCK_BYTES - 1;
  localparam int DIV_W    = $clog2(((DIV_TOP > OVER_LIM) ? DIV_TOP : OVER_LIM) + 1);
  localparam int PAD_W    = SIZE_CLASSES + SCAN_LANES;
  // Reciprocal of the block size, exact for every dividend below 2**DIV_W.
  localparam int     BLK_SH  = $clog2(BLOCK_BYTES);
  localparam int     RCP_SH  = DIV_W + BLK_SH;
  localparam int     RCP_W   = DIV_W + 2;
  localparam int     PROD_W  = DIV_W + RCP_W;
  localparam longint RCP_MUL = ((longint'(1) << RCP_SH) + BLOCK_BYTES - 1) / BLOCK_BYTES;

  // Request fields held for the whole transaction.
  logic [CMD_W-1:0]   cmd_r;
  logic [VSIZE_W-1:0] vsize_r;
  logic [OFF_W-1:0]   off_r;
  logic [FCLS_W-1:0]  fcls_r;

  // Allocation state and working registers.
  logic [PIDX_W-1:0]       pidx_r;
  logic [HEAD_W-1:0]       head_r;
  logic [SIZE_CLASSES-1:0] nonempty_r;
  logic [CLS_W-1:0]        cls_r;
  logic [SCAN_W-1:0]       cursor_r;
  logic [BLK_W-1:0]        blocks_r;
  logic                    oversize_r;

  // Result staging and response register.
  logic [STATUS_W-1:0] res_status_r;
  logic [OFF_W-1:0]    res_offset_r;
  logic [BLK_W-1:0]    res_blocks_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [OFF_W-1:0]    out_offset_r;
  logic [BLK_W-1:0]    out_blocks_r;

  logic [BLK_W-1:0]  blocks_c;
  logic              oversize_c;
  logic [HEAD_W:0]   head_sum;
  logic              log_fits;
  logic [OFF_W-1:0]  base;
  logic [OFF_W-1:0]  granted;
  logic [PAD_W-1:0]  padded;
  logic [PAD_W-1:0]  window;
  logic [SCAN_LANES-1:0] lanes;
  logic              hit;
  logic [LANE_W-1:0] hit_lane;
  logic [SCAN_W-1:0] hit_sum;
  logic [CLS_W-1:0]  hit_cls;
  logic              scan_done;
  logic [CNT_W-1:0]  cnt_rdata;
  logic [CNT_W-1:0]  cnt_cur;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [CLS_W-1:0]  cnt_raddr;
  logic              cnt_we;
  logic              fcls_ok;
  logic              free_ok;
  logic [ST_AW-1:0]  st_base;
  logic [ST_AW-1:0]  st_addr;
  logic [OFF_W-1:0]  st_rdata;
  logic              st_we;

  // Block count: ceiling division by the block size as a reciprocal multiply.
  always_comb begin
    logic [DIV_W-1:0]  rem;
    logic [PROD_W-1:0] prod;
    rem        = DIV_W'(vsize_r) + DIV_W'(HEADER_BYTES + BLOCK_BYTES - 1);
    prod       = PROD_W'(rem) * PROD_W'(RCP_MUL);
    blocks_c   = prod[RCP_SH +: BLK_W];
    oversize_c = (int'(vsize_r) > MAX_VALUE) || (rem >= DIV_W'(OVER_LIM));
  end

  // Log bump check and granted offset.
  assign head_sum = {1'b0, head_r} + (HEAD_W + 1)'(blocks_r);
  assign log_fits = head_sum < (HEAD_W + 1)'(REGION_BLOCKS);
  assign base     = OFF_W'(pidx_r) * OFF_W'(REGION_BLOCKS);
  assign granted  = OFF_W'(head_r) + base;

  // Free-list search: a window of classes starting at the cursor.
  assign padded  = {{SCAN_LANES{1'b0}}, nonempty_r};
  assign window  = padded >> cursor_r;
  assign lanes   = window[SCAN_LANES-1:0];
  assign hit     = |lanes;
  assign hit_sum = cursor_r + SCAN_W'(hit_lane);
  assign hit_cls = hit_sum[CLS_W-1:0];
  assign scan_done = cursor_r >= SCAN_W'(SIZE_CLASSES);

  always_comb begin
    hit_lane = '0;
    for (int i = SCAN_LANES - 1; i >= 0; i--) begin
      if (lanes[i]) begin
        hit_lane = LANE_W'(i);
      end
    end
  end

  // Class counts: an empty class reads as zero whatever the memory holds.
  assign cnt_raddr = cmd_i.scan_step ? hit_cls : cls_r;
  assign cnt_cur   = nonempty_r[cls_r] ? cnt_rdata : '0;
  assign cnt_dec   = cnt_cur - CNT_W'(1);
  assign fcls_ok   = int'(fcls_r) < SIZE_CLASSES;
  assign free_ok   = fcls_ok && (cnt_cur < CNT_W'(LIST_DEPTH));
  assign st_we     = cmd_i.free_commit && free_ok;
  assign cnt_we    = st_we || cmd_i.pop_count;
  assign cnt_wdata = cmd_i.pop_count ? cnt_dec : cnt_cur + CNT_W'(1);

  // Extent store address: class row plus position in the stack.
  assign st_base = ST_AW'(cls_r) * ST_AW'(LIST_DEPTH);
  assign st_addr = st_base + (cmd_i.pop_count ? ST_AW'(cnt_dec) : ST_AW'(cnt_cur));

  sba_ram #(
    .WIDTH (CNT_W),
    .DEPTH (SIZE_CLASSES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cls_r),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  sba_ram #(
    .WIDTH (OFF_W),
    .DEPTH (SIZE_CLASSES * LIST_DEPTH)
  ) u_store_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_addr),
    .wdata (off_r),
    .raddr (st_addr),
    .rdata (st_rdata)
  );

  // Control state: configuration, log head, class occupancy, response valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pidx_r      <= '0;
      head_r      <= '0;
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pidx_r <= cfg_wdata_i;
      end
      if (cmd_i.log_grant) begin
        head_r <= head_sum[HEAD_W-1:0];
      end
      if (st_we) begin
        nonempty_r[cls_r] <= 1'b1;
      end else if (cmd_i.pop_count && (cnt_dec == '0)) begin
        nonempty_r[cls_r] <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    blocks_r   <= blocks_c;
    oversize_r <= oversize_c;
    if (cmd_i.load) begin
      cmd_r   <= in_cmd_i;
      vsize_r <= in_value_size_i;
      off_r   <= in_free_offset_i;
      fcls_r  <= in_free_class_i;
      cls_r   <= CLS_W'(in_free_class_i);
    end else if (cmd_i.scan_step && hit) begin
      cls_r <= hit_cls;
    end
    if (cmd_i.scan_start) begin
      cursor_r <= SCAN_W'(blocks_r);
    end else if (cmd_i.scan_step) begin
      cursor_r <= cursor_r + SCAN_W'(SCAN_LANES);
    end
    priority if (cmd_i.nospace) begin
      res_status_r <= ST_NOSPACE;
      res_offset_r <= '0;
      res_blocks_r <= '0;
    end else if (cmd_i.log_grant) begin
      res_status_r <= ST_LOG;
      res_offset_r <= granted;
      res_blocks_r <= blocks_r;
    end else if (cmd_i.free_commit) begin
      res_status_r <= free_ok ? ST_FREED : ST_FULL;
      res_offset_r <= '0;
      res_blocks_r <= '0;
    end else if (cmd_i.list_result) begin
      res_status_r <= ST_LIST;
      res_offset_r <= st_rdata;
      res_blocks_r <= BLK_W'(cls_r);
    end else begin
      res_status_r <= res_status_r;
    end
    if (cmd_i.out_load) begin
      out_status_r <= res_status_r;
      out_offset_r <= res_offset_r;
      out_blocks_r <= res_blocks_r;
    end
  end

  assign stat_o.is_free   = (cmd_r == CMD_FREE);
  assign stat_o.oversize  = oversize_r;
  assign stat_o.log_fits  = log_fits;
  assign stat_o.scan_hit  = hit;
  assign stat_o.scan_done = scan_done;
  assign stat_o.out_free  = !out_valid_r || out_ready_i;

  assign pidx_o       = pidx_r;
  assign out_valid_o  = out_valid_r;
  assign out_status_o = out_status_r;
  assign out_offset_o = out_offset_r;
  assign out_blocks_o = out_blocks_r;

endmodule

// File: hdl/segregated_block_allocator_core.sv
// Channel   Direction  Carries
// in_if     sink       cmd, value_size, free_offset, free_class
// out_if    source     status, offset, blocks_granted
// APB       slave      partition_index at byte address 0
//
// One request is taken at a time. A free passes decode, free write and output;
// a log grant or an oversized request passes decode, allocation check and output;
// a request the log cannot hold adds the class search, eight classes per cycle
// from the requested class up, and a pop then adds the count pop and store read.
// The response register lets a new request enter while the last response waits.
// rst_n is synchronous; it clears the FSM state, log head, class occupancy bits,
// partition index and response valid. The extent store needs no clearing.
module segregated_block_allocator_core #(
  parameter int BLOCK_BYTES   = sba_pkg::DEF_BLOCK_BYTES,
  parameter int HEADER_BYTES  = sba_pkg::DEF_HEADER_BYTES,
  parameter int SIZE_CLASSES  = sba_pkg::DEF_SIZE_CLASSES,
  parameter int LIST_DEPTH    = sba_pkg::DEF_LIST_DEPTH,
  parameter int REGION_BLOCKS = sba_pkg::DEF_REGION_BLOCKS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  sba_in_if.sink                       in_if,
  sba_out_if.source                    out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sba_pkg::APB_AW-1:0]   paddr,
  input  logic [sba_pkg::APB_DW-1:0]   pwdata,
  output logic [sba_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import sba_pkg::*;

  sba_cmd_t          cmd;
  sba_stat_t         stat;
  logic              in_ready;
  logic              cfg_we;
  logic [PIDX_W-1:0] pidx;

  // Register write at the access phase; only the first word is decoded.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : APB_DW'(pidx);

  assign in_if.ready = in_ready;

  sba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sba_datapath #(
    .BLOCK_BYTES   (BLOCK_BYTES),
    .HEADER_BYTES  (HEADER_BYTES),
    .SIZE_CLASSES  (SIZE_CLASSES),
    .LIST_DEPTH    (LIST_DEPTH),
    .REGION_BLOCKS (REGION_BLOCKS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .in_cmd_i         (in_if.cmd),
    .in_value_size_i  (in_if.value_size),
    .in_free_offset_i (in_if.free_offset),
    .in_free_class_i  (in_if.free_class),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (pwdata[PIDX_W-1:0]),
    .pidx_o           (pidx),
    .out_valid_o      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .out_status_o     (out_if.status),
    .out_offset_o     (out_if.offset),
    .out_blocks_o     (out_if.blocks_granted)
  );

endmodule

// File: tb/tb.sv
module tb;
  import sba_pkg::*;

  localparam logic [APB_AW-1:0] PIDX_ADDR = '0;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_PRINTS    = 50;
  localparam int TOP_SIZE      = (1 << VSIZE_W) - 1;
  // Block count of the largest legal value.
  localparam int TOP_BLOCKS =
      (MAX_VALUE + DEF_HEADER_BYTES + DEF_BLOCK_BYTES - 1) / DEF_BLOCK_BYTES;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VSIZE_W-1:0] value_size;
    logic [OFF_W-1:0]   free_offset;
    logic [FCLS_W-1:0]  free_class;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    offset;
    logic [BLK_W-1:0]    blocks;
  } response_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sba_in_if  req_if ();
  sba_out_if rsp_if ();

  segregated_block_allocator_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (req_if),
    .out_if  (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Allocator shadow: partition, log head and the per-class extent stacks.
  logic [PIDX_W-1:0] model_partition;
  int unsigned       model_head;
  logic [OFF_W-1:0]  model_extents [DEF_SIZE_CLASSES][DEF_LIST_DEPTH];
  int unsigned       model_fill [DEF_SIZE_CLASSES];

  request_t  req_backlog[$];
  response_t awaited_responses[$];

  bit req_taken;
  bit rsp_taken;
  int src_gap;
  int src_calm;
  int sink_stall;
  int sink_calm;
  int quiet_cycles;
  int mismatches;
  int served;
  int status_tally [8];

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("MISMATCH @%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Appends one request at the tail of the backlog.
  function automatic void backlog_add(input request_t r);
    req_backlog.insert(req_backlog.size(), r);
  endfunction

  // Idle stretch length: mostly short, now and then long.
  function automatic int idle_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic request_t make_alloc(input int unsigned size);
    request_t r;
    r.cmd         = CMD_ALLOC;
    r.value_size  = VSIZE_W'(size);
    r.free_offset = $urandom;
    r.free_class  = FCLS_W'($urandom);
    return r;
  endfunction

  function automatic request_t make_free(input logic [OFF_W-1:0] off, input int unsigned cls);
    request_t r;
    r.cmd         = CMD_FREE;
    r.value_size  = VSIZE_W'($urandom);
    r.free_offset = off;
    r.free_class  = FCLS_W'(cls);
    return r;
  endfunction

  // Random mix of frees and allocations, weighted toward the classes that
  // allocations of legal values can ask for.
  function automatic request_t random_request();
    int unsigned pick;
    logic [OFF_W-1:0] off;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) off = '0;
      else if (pick < 10) off = '1;
      else off = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 85) return make_free(off, $urandom_range(1, TOP_BLOCKS));
      if (pick < 95) return make_free(off, $urandom_range(TOP_BLOCKS + 1, DEF_SIZE_CLASSES - 1));
      return make_free(off, 0);
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) return make_alloc($urandom_range(MAX_VALUE + 1, TOP_SIZE));
    if (pick < 20) return make_alloc($urandom_range(0, 42));
    if (pick < 25) return make_alloc(MAX_VALUE);
    return make_alloc($urandom_range(0, MAX_VALUE));
  endfunction

  // Expected response of one request; updates the shadow state.
  function automatic response_t allocate_or_free(input request_t r);
    response_t   rsp;
    int unsigned need;
    int unsigned cls;
    rsp        = '0;
    rsp.status = ST_NOSPACE;
    if (r.cmd == CMD_FREE) begin
      cls = r.free_class;
      if (cls >= DEF_SIZE_CLASSES || model_fill[cls] >= DEF_LIST_DEPTH) begin
        rsp.status = ST_FULL;
      end else begin
        model_extents[cls][model_fill[cls]] = r.free_offset;
        model_fill[cls]++;
        rsp.status = ST_FREED;
      end
      return rsp;
    end
    // Oversized values leave every piece of state alone.
    if (r.value_size > MAX_VALUE) return rsp;
    need = (r.value_size + DEF_HEADER_BYTES + DEF_BLOCK_BYTES - 1) / DEF_BLOCK_BYTES;
    if (need > MAX_BLOCKS) return rsp;
    // Bump the log while the extent stays strictly inside the region.
    if (model_head + need < DEF_REGION_BLOCKS) begin
      rsp.status = ST_LOG;
      rsp.offset = OFF_W'(longint'(model_head) +
                          longint'(model_partition) * DEF_REGION_BLOCKS);
      rsp.blocks = BLK_W'(need);
      model_head += need;
      return rsp;
    end
    // Otherwise pop the newest extent of the smallest class that fits.
    for (cls = need; cls < DEF_SIZE_CLASSES; cls++) begin
      if (model_fill[cls] != 0) begin
        model_fill[cls]--;
        rsp.status = ST_LIST;
        rsp.offset = model_extents[cls][model_fill[cls]];
        rsp.blocks = BLK_W'(cls);
        return rsp;
      end
    end
    return rsp;
  endfunction

  // Request driver: offers the backlog with random gaps between transactions.
  always @(negedge clk) begin : drive_requests
    request_t next_req;
    int       pick;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (src_gap > 0) begin
        req_if.valid <= 1'b0;
        src_gap--;
      end else if (req_backlog.size() != 0) begin
        next_req = req_backlog.pop_front();
        req_if.cmd         <= next_req.cmd;
        req_if.value_size  <= next_req.value_size;
        req_if.free_offset <= next_req.free_offset;
        req_if.free_class  <= next_req.free_class;
        req_if.valid       <= 1'b1;
        // Gap to leave once this transaction is taken.
        pick = $urandom_range(0, 99);
        if (src_calm > 0) begin
          src_calm--;
          src_gap = 0;
        end else if (pick < 3) begin
          src_calm = $urandom_range(20, 60);
          src_gap  = 0;
        end else if (pick < 55) begin
          src_gap = 0;
        end else begin
          src_gap = idle_length();
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response sink: random stalls with occasional stretches of steady ready.
  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      rsp_if.ready <= 1'b0;
      sink_stall--;
    end else begin
      rsp_if.ready <= 1'b1;
      if (sink_calm > 0) sink_calm--;
      else if ($urandom_range(0, 99) < 2) sink_calm = $urandom_range(100, 300);
      else if ($urandom_range(0, 99) < 25) sink_stall = idle_length();
    end
  end

  // Monitor: predicts each accepted request, checks each accepted response,
  // and watches for a stalled run.
  always @(posedge clk) begin : observe
    request_t  seen_req;
    response_t want;
    req_taken = rst_n && req_if.valid && req_if.ready;
    rsp_taken = rst_n && rsp_if.valid && rsp_if.ready;
    if (req_taken) begin
      seen_req = {req_if.cmd, req_if.value_size, req_if.free_offset, req_if.free_class};
      awaited_responses.insert(awaited_responses.size(), allocate_or_free(seen_req));
      served++;
    end
    if (rsp_taken) begin
      if (awaited_responses.size() == 0) begin
        report_mismatch("response with no request outstanding", rsp_if.status, '0);
      end else begin
        want = awaited_responses.pop_front();
        status_tally[want.status]++;
        if (rsp_if.status !== want.status)
          report_mismatch("status", rsp_if.status, want.status);
        if (rsp_if.offset !== want.offset)
          report_mismatch("offset", rsp_if.offset, want.offset);
        if (rsp_if.blocks_granted !== want.blocks)
          report_mismatch("blocks_granted", rsp_if.blocks_granted, want.blocks);
      end
    end
    if (req_taken || rsp_taken) begin
      quiet_cycles = 0;
    end else if (rst_n) begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("No transaction for %0d cycles, %0d responses outstanding.",
                 STALL_LIMIT, awaited_responses.size());
        $display("segregated_block_allocator_core verification failed");
        $finish;
      end
    end
  end

  // Writes the partition register and reads it back.
  task automatic set_partition(input logic [PIDX_W-1:0] idx);
    logic [APB_DW-1:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PIDX_ADDR;
    pwdata  <= APB_DW'(idx);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model_partition = idx;
    // Read transaction right behind the write.
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[PIDX_W-1:0] !== idx)
      report_mismatch("partition_index readback", readback, APB_DW'(idx));
  endtask

  // Block until every queued request has been answered.
  task automatic wait_drained();
    while (req_backlog.size() != 0 || req_if.valid || awaited_responses.size() != 0)
      @(posedge clk);
  endtask

  initial begin : run
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_if.valid       = 1'b0;
    req_if.cmd         = CMD_ALLOC;
    req_if.value_size  = '0;
    req_if.free_offset = '0;
    req_if.free_class  = '0;
    rsp_if.ready       = 1'b0;
    model_partition    = '0;
    model_head         = 0;
    foreach (model_fill[i]) model_fill[i] = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests in the top partition.
    set_partition(4'd15);
    // Rounding at the block edges: 0 and 10 bytes fit one block, 11 needs two.
    backlog_add(make_alloc(0));
    backlog_add(make_alloc(10));
    backlog_add(make_alloc(11));
    backlog_add(make_alloc(42));
    backlog_add(make_alloc(43));
    backlog_add(make_alloc(1));
    backlog_add(make_alloc(MAX_VALUE - 1));
    backlog_add(make_alloc(MAX_VALUE));
    // Oversized values are refused and leave the log head alone.
    backlog_add(make_alloc(MAX_VALUE + 1));
    backlog_add(make_alloc(TOP_SIZE));
    // Frees at the extreme offsets and classes.
    backlog_add(make_free('0, 1));
    backlog_add(make_free('1, DEF_SIZE_CLASSES - 1));
    backlog_add(make_free(32'h8000_0000, 0));
    backlog_add(make_free(32'h5555_aaaa, TOP_BLOCKS));
    backlog_add(make_free(32'h0000_0001, 2));
    backlog_add(make_alloc(500));
    wait_drained();

    // A short random mix, then overflow the list of class zero.
    set_partition('0);
    repeat (40) backlog_add(random_request());
    repeat (DEF_LIST_DEPTH + 6) backlog_add(make_free($urandom, 0));
    wait_drained();

    // Random traffic in another partition with one list already full.
    set_partition(4'd6);
    repeat (40) backlog_add(random_request());
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests over partitions 15, 0 and 6, including a full free list.",
             served);
    $display("Responses: %0d log, %0d free list, %0d no space, %0d freed, %0d list full.",
             status_tally[ST_LOG], status_tally[ST_LIST], status_tally[ST_NOSPACE],
             status_tally[ST_FREED], status_tally[ST_FULL]);
    if (mismatches == 0 && awaited_responses.size() == 0) begin
      $display("segregated_block_allocator_core verification clean");
    end else begin
      $display("segregated_block_allocator_core verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sba_pkg.sv
hdl/sba_if.sv
hdl/sba_ram.sv
hdl/sba_ctrl.sv
hdl/sba_datapath.sv
hdl/segregated_block_allocator_core.sv
tb/tb.sv
